// ===== hdl/upd_pkg.sv =====
// Shared types, constants and helper functions for the URL percent decoder.
package upd_pkg;

    localparam logic [7:0] PLUS_CHAR      = 8'h2B;
    localparam logic [7:0] PERCENT_CHAR   = 8'h25;
    localparam logic [7:0] SPACE_CHAR     = 8'h20;
    localparam logic [3:0] HEX_ALPHA_BASE = 4'd10;
    localparam int         MAX_BURST      = 3;
    localparam int         FIFO_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_word_t;

    // One accepted input word turns into a burst of zero to three output bytes; only non-empty bursts are queued.
    typedef struct packed {
        logic [1:0]                 count;
        logic [MAX_BURST-1:0][7:0] bytes;
        logic                       last;
    } burst_t;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                 (c >= 8'h61 && c <= 8'h66);
    endfunction

    // Letters A-F and a-f share the low nibble 1..6.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        if (c <= 8'h39) begin
            hex_value = c[3:0];
        end else begin
            hex_value = c[3:0] + HEX_ALPHA_BASE - 4'd1;
        end
    endfunction

endpackage

// ===== hdl/upd_front.sv =====
// Front end: accepts input words, tracks the escape state, builds output bursts.
module upd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  upd_pkg::in_word_t s_data,
    input  logic              q_full,
    output logic              q_push,
    output upd_pkg::burst_t   q_burst
);

    localparam logic [1:0] PHASE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_PCT   = 2'd1;
    localparam logic [1:0] PHASE_DIGIT = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        logic [7:0] b;
        logic       last;
        logic       b_hex;
        logic       do_plain;
        logic [1:0] pre;

        b        = s_data.in_byte;
        last     = s_data.in_last;
        b_hex    = upd_pkg::is_hex(b);
        do_plain = 1'b1;
        pre      = 2'd0;

        phase_next    = PHASE_IDLE;
        held_next     = held_reg;
        q_burst       = '0;
        q_burst.last  = last;

        case (phase_reg)
            PHASE_PCT: begin
                if (b_hex && !last) begin
                    phase_next = PHASE_DIGIT;
                    held_next  = b;
                    do_plain   = 1'b0;
                end else begin
                    q_burst.bytes[0] = upd_pkg::PERCENT_CHAR;
                    pre              = 2'd1;
                end
            end
            PHASE_DIGIT: begin
                if (b_hex) begin
                    q_burst.bytes[0] = {upd_pkg::hex_value(held_reg),
                                        upd_pkg::hex_value(b)};
                    q_burst.count    = 2'd1;
                    do_plain         = 1'b0;
                end else begin
                    // Broken escape: pass the percent sign and held digit literally.
                    q_burst.bytes[0] = upd_pkg::PERCENT_CHAR;
                    q_burst.bytes[1] = held_reg;
                    pre              = 2'd2;
                end
            end
            default: begin
                pre = 2'd0;
            end
        endcase

        if (do_plain) begin
            q_burst.count = pre;
            if (b == upd_pkg::PERCENT_CHAR && !last) begin
                phase_next = PHASE_PCT;
            end else begin
                q_burst.bytes[pre] = (b == upd_pkg::PLUS_CHAR) ? upd_pkg::SPACE_CHAR : b;
                q_burst.count      = pre + 2'd1;
            end
        end
    end

    assign q_push = accept && (q_burst.count != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_IDLE;
            held_reg  <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== hdl/upd_fifo.sv =====
// Short burst queue between the front end and the output side.
module upd_fifo #(
    parameter int DEPTH = upd_pkg::FIFO_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  upd_pkg::burst_t wr_data,
    input  logic            pop,
    output upd_pkg::burst_t rd_data,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    upd_pkg::burst_t    slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("burst queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("burst queue read while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("burst queue fill count out of range");

endmodule

// ===== hdl/upd_back.sv =====
// Back end: drains queued bursts into the output register one byte per cycle unless m_ready stalls it.
module upd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  upd_pkg::burst_t    q_burst,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output upd_pkg::out_word_t m_data
);

    logic [1:0]         idx_reg, idx_next;
    logic               valid_reg, valid_next;
    upd_pkg::out_word_t data_reg;
    logic               load;
    logic               final_byte;

    assign load       = !q_empty && (!valid_reg || m_ready);
    assign final_byte = (idx_reg == q_burst.count - 2'd1);
    assign q_pop      = load && final_byte;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = final_byte ? 2'd0 : idx_reg + 2'd1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg.out_byte <= q_burst.bytes[idx_reg];
            data_reg.out_last <= q_burst.last && final_byte;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    a_idx_in_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_empty |-> (idx_reg < q_burst.count))
        else $error("burst index past burst length");

endmodule

// ===== hdl/url_percent_decoder_unit.sv =====
// Top level of the streaming URL percent decoder.
//
// Decodes form-encoded text one byte per cycle while not stalled: '+' becomes a
// space, '%' with two hex digits becomes the byte they spell, and a broken escape
// is passed literally. One input word is accepted per cycle while the burst queue
// has room; each word yields zero to three output words, which the output side sends
// one per cycle while m_ready allows, so a broken escape yields up to three output
// words for one input word. Each output word passes through the burst queue and the
// output register. The burst queue lets the next input word in while a result still
// waits in the output register. The final output word of a string carries out_last.
module url_percent_decoder_unit #(
    parameter int FIFO_DEPTH = upd_pkg::FIFO_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  upd_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output upd_pkg::out_word_t m_data
);

    upd_pkg::burst_t wr_burst;
    upd_pkg::burst_t rd_burst;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;

    upd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_burst (wr_burst)
    );

    upd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (wr_burst),
        .pop     (q_pop),
        .rd_data (rd_burst),
        .full    (q_full),
        .empty   (q_empty)
    );

    upd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_burst (rd_burst),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== verif/url_percent_decoder_unit_test.sv =====
// Self-checking testbench for the URL percent decoder with random strings and stalls.
module url_percent_decoder_unit_test;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 64;
    localparam int WORD_TARGET  = 450;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PERCENT,
        ESC_DIGIT
    } escape_state_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    upd_pkg::in_word_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    upd_pkg::out_word_t m_data;

    upd_pkg::in_word_t  encoded_words[$];
    upd_pkg::out_word_t decoded_words[$];
    escape_state_t      esc_state   = ESC_NONE;
    logic [7:0]         held_char   = '0;
    int                 error_count = 0;
    int                 idle_cycles = 0;
    int                 send_gap    = 0;
    int                 hold_left   = 0;
    bit                 send_calm   = 1'b0;
    bit                 recv_calm   = 1'b0;

    url_percent_decoder_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit is_hex_char(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] nibble_of(logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61) begin
            v = c - 8'h61 + 8'd10;
        end else begin
            v = c - 8'h41 + 8'd10;
        end
        return v[3:0];
    endfunction

    function automatic int pick_idle(bit calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] random_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) begin
            return 8'h30 + v[7:0];
        end else if ($urandom_range(0, 1) == 0) begin
            return 8'h41 + v[7:0] - 8'd10;
        end
        return 8'h61 + v[7:0] - 8'd10;
    endfunction

    task automatic push_decoded(logic [7:0] b, logic last);
        upd_pkg::out_word_t w;
        w.out_byte = b;
        w.out_last = last;
        decoded_words.push_back(w);
    endtask

    // Decode one byte with no escape pending.
    task automatic decode_plain(logic [7:0] b, logic last);
        if (b == upd_pkg::PERCENT_CHAR && !last) begin
            esc_state = ESC_PERCENT;
        end else if (b == upd_pkg::PLUS_CHAR) begin
            push_decoded(upd_pkg::SPACE_CHAR, last);
        end else begin
            push_decoded(b, last);
        end
    endtask

    task automatic decode_word(upd_pkg::in_word_t w);
        escape_state_t st;
        st = esc_state;
        esc_state = ESC_NONE;
        case (st)
            ESC_PERCENT: begin
                if (is_hex_char(w.in_byte) && !w.in_last) begin
                    esc_state = ESC_DIGIT;
                    held_char = w.in_byte;
                end else begin
                    push_decoded(upd_pkg::PERCENT_CHAR, 1'b0);
                    decode_plain(w.in_byte, w.in_last);
                end
            end
            ESC_DIGIT: begin
                if (is_hex_char(w.in_byte)) begin
                    push_decoded({nibble_of(held_char), nibble_of(w.in_byte)}, w.in_last);
                end else begin
                    // broken escape: flush percent and held digit literally
                    push_decoded(upd_pkg::PERCENT_CHAR, 1'b0);
                    push_decoded(held_char, 1'b0);
                    decode_plain(w.in_byte, w.in_last);
                end
            end
            default: begin
                decode_plain(w.in_byte, w.in_last);
            end
        endcase
    endtask

    task automatic add_word(logic [7:0] b, logic last);
        upd_pkg::in_word_t w;
        w.in_byte = b;
        w.in_last = last;
        encoded_words.push_back(w);
    endtask

    // Mostly well-formed text with random content, some broken escapes.
    task automatic add_random_string();
        upd_pkg::in_word_t str[$];
        upd_pkg::in_word_t w;
        int                len;
        int                kind;
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
            kind = $urandom_range(0, 99);
            w.in_last = 1'b0;
            if (kind < 45) begin
                w.in_byte = 8'($urandom_range(0, 255));
                str.push_back(w);
            end else if (kind < 60) begin
                w.in_byte = upd_pkg::PLUS_CHAR;
                str.push_back(w);
            end else if (kind < 88) begin
                w.in_byte = upd_pkg::PERCENT_CHAR;
                str.push_back(w);
                w.in_byte = random_hex_char();
                str.push_back(w);
                w.in_byte = random_hex_char();
                str.push_back(w);
            end else begin
                w.in_byte = upd_pkg::PERCENT_CHAR;
                str.push_back(w);
                if ($urandom_range(0, 1) == 0) begin
                    w.in_byte = random_hex_char();
                    str.push_back(w);
                end
            end
        end
        w = str.pop_back();
        w.in_last = 1'b1;
        str.push_back(w);
        foreach (str[i]) begin
            encoded_words.push_back(str[i]);
        end
    endtask

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("ERROR at %0t: %s: got %02h, expected %02h", $realtime, what, got, want);
        error_count++;
    endtask

    // Input side: hold the word until accepted, then predict and advance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                decode_word(s_data);
            end
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (encoded_words.size() > 0) begin
                s_data  <= encoded_words.pop_front();
                s_valid <= 1'b1;
                if ($urandom_range(0, 59) == 0) begin
                    send_calm = !send_calm;
                end
                send_gap = pick_idle(send_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Output side: check each accepted word against the oldest prediction.
    always @(posedge aclk) begin
        upd_pkg::out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (decoded_words.size() == 0) begin
                    report_mismatch("word with nothing pending", m_data.out_byte, 8'h00);
                end else begin
                    want = decoded_words.pop_front();
                    if (m_data.out_byte !== want.out_byte) begin
                        report_mismatch("out_byte", m_data.out_byte, want.out_byte);
                    end
                    if (m_data.out_last !== want.out_last) begin
                        report_mismatch("out_last", {7'd0, m_data.out_last},
                                        {7'd0, want.out_last});
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 59) == 0) begin
                    recv_calm = !recv_calm;
                end
                hold_left = pick_idle(recv_calm);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("url_percent_decoder_unit_test NOT OK");
                $finish;
            end
        end
    end

    initial begin
        add_word(upd_pkg::PLUS_CHAR, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'hFF, 1'b1);
        add_word(upd_pkg::PERCENT_CHAR, 1'b0);
        add_word("4", 1'b0);
        add_word("1", 1'b0);
        add_word(upd_pkg::PERCENT_CHAR, 1'b0);
        add_word("0", 1'b0);
        add_word("0", 1'b0);
        // non-hex follower
        add_word(upd_pkg::PERCENT_CHAR, 1'b0);
        add_word("G", 1'b0);
        add_word(upd_pkg::PERCENT_CHAR, 1'b0);
        add_word("4", 1'b0);
        add_word("z", 1'b0);
        // broken escape whose follower starts a new escape
        add_word(upd_pkg::PERCENT_CHAR, 1'b0);
        add_word("a", 1'b0);
        add_word(upd_pkg::PERCENT_CHAR, 1'b0);
        add_word("2", 1'b0);
        add_word("0", 1'b0);
        // string ends mid-escape
        add_word(upd_pkg::PERCENT_CHAR, 1'b1);
        add_word(upd_pkg::PERCENT_CHAR, 1'b0);
        add_word("9", 1'b1);
        add_word(upd_pkg::PERCENT_CHAR, 1'b0);
        add_word("b", 1'b0);
        add_word(upd_pkg::PERCENT_CHAR, 1'b1);
        add_word(upd_pkg::PERCENT_CHAR, 1'b0);
        add_word("f", 1'b0);
        add_word("F", 1'b1);
        while (encoded_words.size() < WORD_TARGET) begin
            add_random_string();
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        do begin
            @(posedge aclk);
        end while (encoded_words.size() != 0 || s_valid || decoded_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && decoded_words.size() == 0) begin
            $display("url_percent_decoder_unit_test OK");
        end else begin
            $display("url_percent_decoder_unit_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== url_percent_decoder_unit.f =====
hdl/upd_pkg.sv
hdl/upd_front.sv
hdl/upd_fifo.sv
hdl/upd_back.sv
hdl/url_percent_decoder_unit.sv
verif/url_percent_decoder_unit_test.sv
